[hdl/thx_pkg.sv]
// Shared types, constants and the threshold function of the halftone expander.
// No dependencies; imported by every module of the block.
package thx_pkg;

  localparam int PIX_W          = 8;
  localparam int DIM_W          = 13;
  localparam int CNT_W          = 12;
  localparam int COORD_W        = 16;
  localparam int PAT_W          = 16;
  localparam int CELL_W         = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_DIM        = 4096;
  localparam int BLOCK_SIZE_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Destination of one block: base row and leftmost column
  typedef struct packed {
    logic [COORD_W-1:0] row_base;
    logic [COORD_W-1:0] col;
  } pos_t;

  // Each base-4 digit d of the cell index maps to (4 - d) mod 4
  function automatic logic [CELL_W-1:0] cell_threshold(input logic [CELL_W-1:0] k);
    logic [CELL_W-1:0] t;
    t = '0;
    for (int j = 0; j < CELL_W / 2; j++) begin
      t[2*j +: 2] = 2'(2'd0 - k[2*j +: 2]);
    end
    return t;
  endfunction

endpackage

[hdl/thx_position.sv]
// Geometry registers and source raster counters of the halftone expander.
// Depends on thx_pkg.
module thx_position import thx_pkg::*; #(
  parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 advance,
  output pos_t                 pos
);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;
  logic             row_end;
  logic             image_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp geometry to 1..MAX_DIM
  always_comb begin
    if (image_width == '0)                    width_eff = DIM_W'(1);
    else if (image_width > DIM_W'(MAX_DIM))   width_eff = DIM_W'(MAX_DIM);
    else                                      width_eff = image_width;
    if (image_height == '0)                   height_eff = DIM_W'(1);
    else if (image_height > DIM_W'(MAX_DIM))  height_eff = DIM_W'(MAX_DIM);
    else                                      height_eff = image_height;
  end

  assign row_end   = ({1'b0, column_count} + DIM_W'(1)) >= width_eff;
  assign image_end = ({1'b0, row_count} + DIM_W'(1)) >= height_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= image_end ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

  assign pos.row_base = COORD_W'(row_count * BLOCK_SIZE);
  assign pos.col      = COORD_W'(column_count * BLOCK_SIZE);

endmodule

[hdl/thx_pattern_row.sv]
// One block row of threshold compares: bit c is white when pixel >= threshold.
// Depends on thx_pkg (cell_threshold).
module thx_pattern_row import thx_pkg::*; #(
  parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
  parameter int PHW        = $clog2(BLOCK_SIZE)
) (
  input  logic [PIX_W-1:0] pixel,
  input  logic [PHW-1:0]   row,
  output logic [PAT_W-1:0] pattern
);

  always_comb begin
    logic [CELL_W-1:0] k;
    pattern = '0;
    for (int c = 0; c < BLOCK_SIZE; c++) begin
      k = CELL_W'(int'(row) * BLOCK_SIZE + c);
      pattern[c] = pixel >= cell_threshold(k);
    end
  end

endmodule

[hdl/threshold_halftone_expander_top.sv]
// Top level of the threshold halftone expander: job register, row sequencer,
// output register. Depends on thx_pkg, thx_position, thx_pattern_row.
//
//  channel | dir | beat content
//  s_axis  | in  | tdata: grey_level
//  m_axis  | out | tdata: target_row, target_col, pattern; tlast: last block row
//  cfg     | in  | cfg_index, cfg_data (image_width, image_height)
//
// Each pixel yields BLOCK_SIZE row beats, one per cycle while m_tready does not stall;
// the row sequencer feeds them into the single output register.
// The next pixel is taken in the cycle its predecessor's last row moves into
// the output register.
// Reset (rst, synchronous) clears counters, geometry to 1x1, all valid flags.
// A stall on m_tready holds the output register and the sequencer.
module threshold_halftone_expander_top import thx_pkg::*; #(
  parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] grey_level
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,   // [15:0] target_row, [31:16] target_col, [47:32] pattern
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int PHW = $clog2(BLOCK_SIZE);
  localparam logic [PHW-1:0] PH_LAST = PHW'(BLOCK_SIZE - 1);

  logic               in_accept;
  logic               advance;
  logic               job_done;
  logic               job_valid;
  logic [PIX_W-1:0]   job_pixel;
  pos_t               job_pos;
  pos_t               pos;
  logic [PHW-1:0]     phase;
  logic [PAT_W-1:0]   row_pattern;
  logic               out_valid;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic [PAT_W-1:0]   out_pattern;
  logic               out_last;

  assign cfg_ready = 1'b1;

  // Move a row into the output register when it is empty or draining
  assign advance   = job_valid && (!out_valid || m_tready);
  assign job_done  = advance && (phase == PH_LAST);
  assign s_tready  = !job_valid || job_done;
  assign in_accept = s_tvalid && s_tready;

  thx_position #(.BLOCK_SIZE(BLOCK_SIZE)) u_position (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (in_accept),
    .pos       (pos)
  );

  thx_pattern_row #(.BLOCK_SIZE(BLOCK_SIZE), .PHW(PHW)) u_pattern_row (
    .pixel   (job_pixel),
    .row     (phase),
    .pattern (row_pattern)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      phase     <= '0;
    end else begin
      if (in_accept)      job_valid <= 1'b1;
      else if (job_done)  job_valid <= 1'b0;
      if (job_done)       phase <= '0;
      else if (advance)   phase <= phase + PHW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      job_pixel <= s_tdata[PIX_W-1:0];
      job_pos   <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_row     <= job_pos.row_base + COORD_W'(phase);
      out_col     <= job_pos.col;
      out_pattern <= row_pattern;
      out_last    <= phase == PH_LAST;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_pattern, out_col, out_row};
  assign m_tlast  = out_last;

  // A new pixel always starts at block row zero
  a_start_row: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> job_valid && phase == '0)
    else $error("job did not start at row zero");

  // The last row loaded into the output register carries tlast
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    job_done |=> m_tvalid && m_tlast)
    else $error("final block row without tlast");

  // Sequencer rests at row zero when idle
  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    !job_valid |-> phase == '0)
    else $error("row counter moved without a job");

  // A non-final row never carries tlast
  a_mid_row: assert property (@(posedge clk) disable iff (rst)
    (advance && phase != PH_LAST) |=> !m_tlast)
    else $error("tlast on an inner block row");

endmodule

[tb/sv/threshold_halftone_expander_checker.sv]
// Checker for the threshold halftone expander: watches the pixel, row and register
// channels, predicts every block row from the ordered dither matrix and compares.
// Depends on thx_pkg for widths and register indexes.
module threshold_halftone_expander_checker import thx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] grey_level
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [47:0]          m_tdata,   // [15:0] target_row, [31:16] target_col, [47:32] pattern
  input  logic                 m_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   rows_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TILE = 16;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [COORD_W-1:0] target_row;
    logic [COORD_W-1:0] target_col;
    logic [PAT_W-1:0]   pattern;
    logic               last;
  } tile_row_t;

  tile_row_t          tile_rows_q[$];
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [CNT_W-1:0]   src_col;
  logic [CNT_W-1:0]   src_row;
  int                 fail_count;
  int                 row_beats;

  assign mismatches = fail_count;

  // Each base-4 digit d of the cell index becomes (4 - d) mod 4 in place
  function automatic logic [CELL_W-1:0] dither_level(input int cell_idx);
    logic [CELL_W-1:0] level;
    int                digit;
    level = '0;
    for (int pos = 0; pos < 4; pos++) begin
      digit = (cell_idx >> (2 * pos)) & 3;
      level = level | CELL_W'(((4 - digit) % 4) << (2 * pos));
    end
    return level;
  endfunction

  function automatic logic [PAT_W-1:0] dither_pattern(input logic [PIX_W-1:0] pix,
                                                      input int row);
    logic [PAT_W-1:0] bits;
    bits = '0;
    for (int col = 0; col < TILE; col++)
      bits[col] = (pix >= dither_level(row * TILE + col));
    return bits;
  endfunction

  function automatic int clamp_dim(input logic [DIM_W-1:0] dim);
    if (dim == '0) return 1;
    if (int'(dim) > MAX_DIM) return MAX_DIM;
    return int'(dim);
  endfunction

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t ns: row beat %0d: %s", $time, row_beats, msg);
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) report($sformatf("%s expected %h, got %h", field, want, got));
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    tile_row_t want;
    tile_row_t row_item;
    int        w;
    int        h;
    if (rst) begin
      tile_rows_q.delete();
      width_reg  = DIM_W'(1);
      height_reg = DIM_W'(1);
      src_col    = '0;
      src_row    = '0;
      row_beats  = 0;
      rows_pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (tile_rows_q.size() == 0) begin
          report("row beat with nothing expected");
        end else begin
          want = tile_rows_q.pop_front();
          check_field("target_row", want.target_row, m_tdata[15:0]);
          check_field("target_col", want.target_col, m_tdata[31:16]);
          check_field("pattern", want.pattern, m_tdata[47:32]);
          check_field("tlast", 16'(want.last), 16'(m_tlast));
        end
        row_beats++;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg  = cfg_data;
          REG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;  // unmapped index, drop
        endcase
      end

      if (s_tvalid && s_tready) begin
        for (int r = 0; r < TILE; r++) begin
          row_item.target_row = {src_row, 4'(r)};
          row_item.target_col = {src_col, 4'b0000};
          row_item.pattern    = dither_pattern(s_tdata, r);
          row_item.last       = (r == TILE - 1);
          tile_rows_q.push_back(row_item);
        end
        // Advance raster position; a shrunk geometry wraps at once
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (int'(src_col) + 1 >= w) begin
          src_col = '0;
          if (int'(src_row) + 1 >= h) src_row = '0;
          else src_row = src_row + 1'b1;
        end else begin
          src_col = src_col + 1'b1;
        end
      end

      rows_pending <= tile_rows_q.size();
    end
  end

endmodule

[tb/sv/threshold_halftone_expander_top_tb.sv]
// Testbench top for the threshold halftone expander: clock, reset, pixel and
// register stimulus, output back-pressure and the verdict.
// Depends on thx_pkg, threshold_halftone_expander_top and its checker.
module threshold_halftone_expander_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import thx_pkg::*;

  localparam int ITEMS       = 170;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 2 * BLOCK_SIZE_DEF;

  // Indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = '0;  // [7:0] grey_level
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [47:0]          m_tdata;         // [15:0] target_row, [31:16] target_col, [47:32] pattern
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  int mismatches;
  int rows_pending;
  int pixels_sent = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  bit long_hold_req = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  threshold_halftone_expander_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  threshold_halftone_expander_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .rows_pending (rows_pending)
  );

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Pixels go out in bursts; lower valid only when a real gap follows
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        if (s_tvalid) s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    pixels_sent++;
  endtask

  // Stop offering pixels and wait until every block row has come out
  task automatic drain();
    if (s_tvalid) s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (rows_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
      2:       return DIM_W'(MAX_DIM);
      3:       return DIM_W'($urandom_range(1, 8191));
      default: return DIM_W'($urandom_range(1, 5));
    endcase
  endfunction

  // Receiver back-pressure: changing patterns, plus one long hold on request
  initial begin
    rx_mode_e rx_mode;
    int       mode_left;
    rx_mode   = RX_OPEN;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= ((mode_left % 8) >= 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no beat for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int phase;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry 1x1: every pixel is a whole image
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd1);
    send_pixel(8'd254);
    drain();

    // Unmapped indexes, then zero sizes read as 1
    write_reg(REG_SPARE_A, DIM_W'($urandom_range(0, 8191)));
    write_reg(REG_SPARE_B, DIM_W'($urandom_range(0, 8191)));
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, '0);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    drain();

    // Oversized geometry clamps to the maximum
    write_reg(REG_IMAGE_WIDTH, '1);
    write_reg(REG_IMAGE_HEIGHT, '1);
    send_pixel(8'h0F);
    send_pixel(8'hF0);
    repeat (6) send_pixel(8'($urandom_range(0, 255)));
    drain();

    // Shrink the width below the current column mid-image; then wrap the image
    write_reg(REG_IMAGE_WIDTH, DIM_W'(3));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(2));
    send_pixel(8'h80);
    send_pixel(8'h7F);
    repeat (5) send_pixel(8'($urandom_range(0, 255)));
    drain();

    write_reg(REG_IMAGE_WIDTH, DIM_W'(MAX_DIM));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(MAX_DIM));
    repeat (3) send_pixel(8'($urandom_range(0, 255)));
    drain();

    phase = 0;
    while (pixels_sent < ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_IMAGE_WIDTH, pick_dim());
        write_reg(REG_IMAGE_HEIGHT, pick_dim());
      end else begin
        write_reg(REG_IMAGE_HEIGHT, pick_dim());
        write_reg(REG_IMAGE_WIDTH, pick_dim());
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                  DIM_W'($urandom_range(0, 8191)));
      // Hold the receiver off while pixels keep coming so the input backs up
      if (phase == 0 || phase == 4) long_hold_req = 1'b1;
      repeat ($urandom_range(8, 24)) send_pixel(8'($urandom_range(0, 255)));
      drain();
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (rows_pending != 0) $display("%0d block rows never arrived", rows_pending);
    if (mismatches == 0 && rows_pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[threshold_halftone_expander_top.f]
hdl/thx_pkg.sv
hdl/thx_position.sv
hdl/thx_pattern_row.sv
hdl/threshold_halftone_expander_top.sv
tb/sv/threshold_halftone_expander_checker.sv
tb/sv/threshold_halftone_expander_top_tb.sv
